FILE: design/spr_pkg.sv
// Shared types and constants for the stream pattern redactor.
package spr_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W = 5;

  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_HIGH = 2'd2;

  typedef struct packed {
    logic wr;
    logic shift;
    logic active;
  } cell_ctrl_t;

endpackage

FILE: design/stream_pattern_redactor.sv
// Top level of the stream pattern redactor: a chain of window cells and the output drain.
// A result is loaded into the output register in the cycle after the item that causes it is accepted.
// One item is accepted per cycle while in_ready is high; a match holds in_ready low
// while its remaining asterisks drain, and a flush of pending bytes holds it low while they drain.
// Synchronous reset empties the window, drops the output and sets length 1, pattern zero.
module stream_pattern_redactor #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [spr_pkg::BYTE_W-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spr_pkg::BYTE_W-1:0]    out_byte,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] drain_cnt;
  logic             drain_star;
  logic [CFG_DATA_W-1:0] pat_lo;
  logic [CFG_DATA_W-1:0] pat_hi;

  logic [BYTE_W-1:0] eff_c [PATTERN_MAX+1];
  logic              match_c [PATTERN_MAX+1];
  cell_ctrl_t        ctrl [PATTERN_MAX];

  logic out_free, draining, acc, data_acc, flush_acc, full, match, shift;
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_new;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || out_ready;
  assign draining = drain_cnt != '0;
  assign in_ready = out_free && !draining;
  assign acc = in_valid && in_ready;
  assign data_acc = acc && (kind == KIND_DATA);
  assign flush_acc = acc && (kind == KIND_FLUSH);
  assign full = CNT_W'(count + 1'b1) == len;
  assign match = match_c[PATTERN_MAX];
  assign shift = (data_acc && full && !match) || (flush_acc && count != '0) ||
                 (draining && !drain_star && out_free);

  assign len_raw = cfg_data[LEN_W-1:0];
  always_comb begin
    if (len_raw == '0) begin
      len_new = LEN_W'(1);
    end else if (len_raw > LEN_W'(PATTERN_MAX)) begin
      len_new = LEN_W'(PATTERN_MAX);
    end else begin
      len_new = len_raw;
    end
  end

  assign eff_c[PATTERN_MAX] = '0;
  assign match_c[0] = 1'b1;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [BYTE_W-1:0] pat_b;
    logic [BYTE_W-1:0] nbr_b;

    if (i < 8) begin : g_lo
      assign pat_b = pat_lo[BYTE_W*i +: BYTE_W];
    end else begin : g_hi
      assign pat_b = pat_hi[BYTE_W*(i-8) +: BYTE_W];
    end

    assign nbr_b = eff_c[i+1];
    assign ctrl[i].wr = data_acc && (count == CNT_W'(i));
    assign ctrl[i].shift = shift;
    assign ctrl[i].active = CNT_W'(i) < len;

    spr_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .din      (in_byte),
      .nbr      (nbr_b),
      .pat      (pat_b),
      .match_in (match_c[i]),
      .eff      (eff_c[i]),
      .match_out(match_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= CNT_W'(1);
      count <= '0;
      drain_cnt <= '0;
      drain_star <= 1'b0;
      out_valid <= 1'b0;
      pat_lo <= '0;
      pat_hi <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (draining && out_free) begin
        out_valid <= 1'b1;
        out_byte <= drain_star ? STAR_BYTE : eff_c[0];
        last <= drain_cnt == CNT_W'(1);
        drain_cnt <= CNT_W'(drain_cnt - 1'b1);
      end else if (data_acc) begin
        if (full) begin
          out_valid <= 1'b1;
          if (match) begin
            out_byte <= STAR_BYTE;
            last <= len == CNT_W'(1);
            drain_cnt <= CNT_W'(len - 1'b1);
            drain_star <= 1'b1;
            count <= '0;
          end else begin
            out_byte <= eff_c[0];
            last <= 1'b1;
            count <= CNT_W'(len - 1'b1);
          end
        end else begin
          count <= CNT_W'(count + 1'b1);
        end
      end else if (flush_acc && count != '0) begin
        out_valid <= 1'b1;
        out_byte <= eff_c[0];
        last <= count == CNT_W'(1);
        drain_cnt <= CNT_W'(count - 1'b1);
        drain_star <= 1'b0;
        count <= '0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: begin
            len <= CNT_W'(len_new);
            count <= '0;
          end
          REG_PATTERN_BYTES_LOW: begin
            pat_lo <= cfg_data;
          end
          REG_PATTERN_BYTES_HIGH: begin
            pat_hi <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: design/spr_cell.sv
// One window cell: holds a pending byte, compares it with its pattern byte, shifts left.
module spr_cell (
  input  logic                       clk,
  input  spr_pkg::cell_ctrl_t        ctrl,
  input  logic [spr_pkg::BYTE_W-1:0] din,
  input  logic [spr_pkg::BYTE_W-1:0] nbr,
  input  logic [spr_pkg::BYTE_W-1:0] pat,
  input  logic                       match_in,
  output logic [spr_pkg::BYTE_W-1:0] eff,
  output logic                       match_out
);
  import spr_pkg::*;

  logic [BYTE_W-1:0] held;

  assign eff = ctrl.wr ? din : held;
  assign match_out = match_in & (!ctrl.active | (eff == pat));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= nbr;
    end else if (ctrl.wr) begin
      held <= din;
    end
  end

endmodule

FILE: design/spr_checker.sv
// Port-level checker for the stream pattern redactor and its bind to the top level.
module spr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [spr_pkg::BYTE_W-1:0] out_byte,
  input logic                       last
);
  import spr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("Stalled result item changed or dropped.");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input taken while the output register is stalled.");

  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("Input taken in the middle of a result burst.");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("Result burst stopped before its last item.");

endmodule

bind stream_pattern_redactor spr_checker u_spr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .last     (last)
);

FILE: bench/stream_pattern_redactor_tb.sv
// Self-checking testbench for the stream pattern redactor: directed and random byte streams.
module stream_pattern_redactor_tb;
  import spr_pkg::*;

  localparam int PATTERN_MAX = 16;
  localparam int SETTLE_CYCLES = 6;
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 55;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
  } feed_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } emitted_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_ALTERNATE,
    READY_BURSTY
  } rx_pattern_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = KIND_DATA;
  logic [BYTE_W-1:0]     in_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stream_pattern_redactor #(.PATTERN_MAX(PATTERN_MAX)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, updated on every accepted item and register write.
  logic [LEN_W-1:0]      len_reg = 5'd1;
  logic [CFG_DATA_W-1:0] pat_lo = '0;
  logic [CFG_DATA_W-1:0] pat_hi = '0;
  logic [BYTE_W-1:0]     win [PATTERN_MAX];
  int unsigned           win_cnt = 0;

  feed_item_t byte_feed [$];
  emitted_t   redacted_q [$];

  int err_cnt = 0;
  int items_in = 0;
  int bytes_out = 0;
  int stars_out = 0;
  int match_cnt = 0;
  int flush_cnt = 0;
  int cfg_cnt = 0;

  function automatic int unsigned eff_len();
    int unsigned n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] pat_byte(input int unsigned i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  task automatic emit(input logic [BYTE_W-1:0] ch);
    redacted_q.push_back('{ch: ch, last: 1'b0});
  endtask

  task automatic redact_step(input logic k, input logic [BYTE_W-1:0] b);
    int unsigned n_len;
    int unsigned before_cnt;
    bit hit;
    n_len = eff_len();
    before_cnt = redacted_q.size();
    if (k == KIND_FLUSH) begin
      flush_cnt++;
      for (int unsigned i = 0; i < win_cnt; i++) emit(win[i]);
      win_cnt = 0;
    end else begin
      if (win_cnt >= n_len) win_cnt = 0;
      win[win_cnt] = b;
      win_cnt++;
      if (win_cnt == n_len) begin
        hit = 1'b1;
        for (int unsigned i = 0; i < n_len; i++)
          if (win[i] != pat_byte(i)) hit = 1'b0;
        if (hit) begin
          match_cnt++;
          for (int unsigned i = 0; i < n_len; i++) emit(STAR_BYTE);
          win_cnt = 0;
        end else begin
          emit(win[0]);
          for (int unsigned i = 0; i + 1 < n_len; i++) win[i] = win[i+1];
          win_cnt--;
        end
      end
    end
    if (redacted_q.size() > before_cnt) redacted_q[redacted_q.size()-1].last = 1'b1;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_PATTERN_LENGTH: begin
        len_reg = val[LEN_W-1:0];
        win_cnt = 0;
      end
      REG_PATTERN_BYTES_LOW: pat_lo = val;
      REG_PATTERN_BYTES_HIGH: pat_hi = val;
      default: ;
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        redact_step(byte_feed[0].kind, byte_feed[0].data);
        void'(byte_feed.pop_front());
        items_in++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        in_valid <= 1'b1;
        kind <= byte_feed[0].kind;
        in_byte <= byte_feed[0].data;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a pattern that is picked anew whenever the low six bits of rx_tick are zero.
  rx_pattern_t rx_pattern = READY_ALWAYS;
  logic [15:0] rx_tick = '0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_tick <= '0;
    end else begin
      rx_tick <= rx_tick + 16'd1;
      if (rx_tick[5:0] == 6'd0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      case (rx_pattern)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        READY_ALTERNATE: out_ready <= rx_tick[0];
        default: out_ready <= (rx_tick[2:0] >= 3'd5);
      endcase
    end
  end

  // Output checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      bytes_out++;
      if (out_byte == STAR_BYTE) stars_out++;
      if (redacted_q.size() == 0) begin
        $error("unexpected item: out_byte %02h last %0b", out_byte, last);
        err_cnt++;
      end else begin
        if (out_byte !== redacted_q[0].ch) begin
          $error("out_byte mismatch: expected %02h, actual %02h", redacted_q[0].ch, out_byte);
          err_cnt++;
        end
        if (last !== redacted_q[0].last) begin
          $error("last mismatch: expected %0b, actual %0b", redacted_q[0].last, last);
          err_cnt++;
        end
        void'(redacted_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_feed.push_back('{kind: KIND_DATA, data: b});
  endtask

  task automatic push_flush();
    byte_feed.push_back('{kind: KIND_FLUSH, data: BYTE_W'($urandom_range(0, 255))});
  endtask

  task automatic drain();
    while (byte_feed.size() != 0 || in_valid || redacted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, val);
    cfg_cnt++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pattern_from(input logic [BYTE_W-1:0] sym [3]);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = sym[$urandom_range(0, 2)];
    return v;
  endfunction

  task automatic gen_phase(input logic [BYTE_W-1:0] sym [3], input int n_items);
    int produced;
    int roll;
    int unsigned n_len;
    int unsigned cut;
    produced = 0;
    n_len = eff_len();
    while (produced < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        push_flush();
        produced++;
      end else if (roll < 40) begin
        for (int unsigned i = 0; i < n_len; i++) push_byte(pat_byte(i));
        produced += n_len;
      end else if (roll < 50) begin
        cut = $urandom_range(0, n_len - 1);
        for (int unsigned i = 0; i < cut; i++) push_byte(pat_byte(i));
        push_byte(BYTE_W'($urandom_range(0, 255)));
        produced += cut + 1;
      end else begin
        push_byte(($urandom_range(0, 9) < 6) ? sym[$urandom_range(0, 2)]
                                             : BYTE_W'($urandom_range(0, 255)));
        produced++;
      end
    end
    if ($urandom_range(0, 1) == 0) push_flush();
    drain();
  endtask

  initial begin
    logic [BYTE_W-1:0] sym [3];
    logic [LEN_W-1:0]  len_pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: length 1, zero pattern. A zero byte matches, 0xFF passes.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_flush();
    drain();

    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_PATTERN_BYTES_LOW, 64'h636261);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(8'h63);
    drain();

    // A new pattern applies to bytes already waiting in the window.
    push_byte(8'h61);
    push_byte(8'h62);
    drain();
    write_reg(REG_PATTERN_BYTES_LOW, 64'h646261);
    push_byte(8'h64);
    drain();

    // A length write drops pending bytes, so the flush finds nothing.
    push_byte(8'h71);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    push_flush();
    drain();

    // Length zero behaves as length one.
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    push_byte(8'h61);
    drain();

    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    write_reg(REG_PATTERN_BYTES_LOW, '1);
    write_reg(REG_PATTERN_BYTES_HIGH, '1);
    for (int i = 0; i < PATTERN_MAX; i++) push_byte(8'hFF);
    push_byte(8'h00);
    push_flush();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < 3; i++) sym[i] = BYTE_W'($urandom_range(0, 255));
      case (p)
        0: len_pick = 5'd1;
        1: len_pick = 5'd2;
        2: len_pick = 5'd16;
        3: len_pick = 5'd17;
        4: len_pick = 5'd0;
        default: len_pick = LEN_W'($urandom_range(0, 31));
      endcase
      // Phase five keeps the window across the pattern rewrite.
      if (p != 5) write_reg(REG_PATTERN_LENGTH, {59'd0, len_pick});
      if (p == 0) begin
        write_reg(REG_PATTERN_BYTES_LOW, {$urandom, $urandom});
        write_reg(REG_PATTERN_BYTES_HIGH, {$urandom, $urandom});
      end else begin
        write_reg(REG_PATTERN_BYTES_LOW, pattern_from(sym));
        write_reg(REG_PATTERN_BYTES_HIGH, pattern_from(sym));
      end
      if (p == 6) write_reg(REG_UNMAPPED, {$urandom, $urandom});
      gen_phase(sym, PHASE_ITEMS);
    end

    drain();
    $display("Covered %0d input items (%0d flushes) and %0d register writes.",
             items_in, flush_cnt, cfg_cnt);
    $display("Checked %0d output bytes, %0d of them asterisks from %0d matches.",
             bytes_out, stars_out, match_cnt);
    if (err_cnt == 0 && redacted_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
